/* rtl/core/dvfs_gov_pkg.sv */
// shared types, codes and constants for the thermal-throttling dvfs governor
// no dependencies; imported by every module of the block
`default_nettype none

package dvfs_gov_pkg;

	localparam int unsigned CHECK_INTERVAL_DEF = 100;
	localparam int unsigned TURBO_ALLOWED_DEF  = 1;

	localparam int unsigned LEVEL_W = 3;
	localparam int unsigned TEMP_W  = 13;
	localparam int unsigned LOAD_W  = 8;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned IDX_W   = 3;

	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 96;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [TEMP_W-1:0]  temp_t;
	typedef logic [LOAD_W-1:0]  load_t;

	localparam level_t LVL_POWERSAVE = 3'd1;
	localparam level_t LVL_BALANCED  = 3'd2;
	localparam level_t LVL_PERF      = 3'd3;
	localparam level_t LVL_TOP       = 3'd4;

	// most negative s8.4 temperature
	localparam temp_t TEMP_MIN = 13'h1000;

	typedef enum logic [2:0] {
		FN_CHECK,
		FN_LOAD,
		FN_MANUAL,
		FN_BOOST,
		FN_TURBO,
		FN_INSTANT_TURBO,
		FN_STATS_CLR
	} func_t;

	typedef enum logic [1:0] {
		MODE_ONDEMAND,
		MODE_MANUAL,
		MODE_HELD,
		MODE_OFF
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE,
		REG_MIN_LEVEL,
		REG_MAX_LEVEL,
		REG_THERMAL_LIMIT,
		REG_LOAD_LOW,
		REG_LOAD_MEDIUM,
		REG_LOAD_HIGH,
		REG_LOAD_VERY_HIGH
	} reg_idx_t;

	typedef struct packed {
		mode_t  mode;
		level_t min_level;
		level_t max_level;
		temp_t  thermal_limit;
		load_t  load_low;
		load_t  load_medium;
		load_t  load_high;
		load_t  load_very_high;
	} cfg_t;

	typedef struct packed {
		func_t             func;
		logic [TIME_W-1:0] now_ms;
		temp_t             temp_sample;
		load_t             load_sample;
		level_t            wanted_level;
	} item_t;

	typedef struct packed {
		level_t           level;
		logic             level_changed;
		logic             high_voltage;
		logic             throttled;
		logic [CNT_W-1:0] throttle_events;
		logic [CNT_W-1:0] transitions;
		load_t            load_average;
		temp_t            peak_temp;
		logic             boost_on;
		logic             turbo_on;
		logic             rejected;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/dvfs_gov_cfg.sv */
// configuration register bank of the dvfs governor
// depends on dvfs_gov_pkg
`default_nettype none

module dvfs_gov_cfg
	import dvfs_gov_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_ONDEMAND;
			cfg_q.min_level      <= 3'd0;
			cfg_q.max_level      <= LVL_TOP;
			cfg_q.thermal_limit  <= 13'd1280;
			cfg_q.load_low       <= 8'd20;
			cfg_q.load_medium    <= 8'd40;
			cfg_q.load_high      <= 8'd70;
			cfg_q.load_very_high <= 8'd90;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:           cfg_q.mode           <= mode_t'(cfg_data[1:0]);
				REG_MIN_LEVEL:      cfg_q.min_level      <= cfg_data[LEVEL_W-1:0];
				REG_MAX_LEVEL:      cfg_q.max_level      <= cfg_data[LEVEL_W-1:0];
				REG_THERMAL_LIMIT:  cfg_q.thermal_limit  <= cfg_data[TEMP_W-1:0];
				REG_LOAD_LOW:       cfg_q.load_low       <= cfg_data[LOAD_W-1:0];
				REG_LOAD_MEDIUM:    cfg_q.load_medium    <= cfg_data[LOAD_W-1:0];
				REG_LOAD_HIGH:      cfg_q.load_high      <= cfg_data[LOAD_W-1:0];
				REG_LOAD_VERY_HIGH: cfg_q.load_very_high <= cfg_data[LOAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/dvfs_gov_state.sv */
// governor state registers and the per-event update logic
// depends on dvfs_gov_pkg; state advances on each event taken from the input stage
`default_nettype none

module dvfs_gov_state
	import dvfs_gov_pkg::*;
#(
	parameter int unsigned CHECK_INTERVAL = CHECK_INTERVAL_DEF,
	parameter int unsigned TURBO_ALLOWED  = TURBO_ALLOWED_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    res
);

	typedef struct packed {
		level_t            level;
		logic [TIME_W-1:0] last_check;
		load_t             last_load;
		load_t             load_avg;
		temp_t             peak;
		temp_t             last_temp;
		logic              throttle;
		logic [CNT_W-1:0]  thr_cnt;
		logic [CNT_W-1:0]  trans_cnt;
		logic              boost;
		logic              turbo;
	} state_t;

	state_t state_q;
	state_t nxt;

	logic              enabled;
	logic              turbo_ok;
	logic [TIME_W-1:0] since;
	logic              elapsed;
	level_t            mapped;
	level_t            lo;
	level_t            hi;
	level_t            floor_lvl;
	level_t            target;
	logic [10:0]       avg_sum;
	logic              changed;
	logic              rejected;

	assign enabled  = cfg.mode != MODE_OFF;
	assign turbo_ok = enabled && (TURBO_ALLOWED != 0) && !state_q.throttle;
	assign since    = item.now_ms - state_q.last_check;
	assign elapsed  = since >= TIME_W'(CHECK_INTERVAL);

	// load to profile through the four thresholds, then clamp min first, max wins
	always_comb begin
		if (state_q.last_load >= cfg.load_very_high)   mapped = LVL_TOP;
		else if (state_q.last_load >= cfg.load_high)   mapped = LVL_PERF;
		else if (state_q.last_load >= cfg.load_medium) mapped = LVL_BALANCED;
		else if (state_q.last_load >= cfg.load_low)    mapped = LVL_POWERSAVE;
		else                                           mapped = 3'd0;
		lo        = (cfg.min_level > LVL_TOP) ? LVL_TOP : cfg.min_level;
		hi        = (cfg.max_level > LVL_TOP) ? LVL_TOP : cfg.max_level;
		floor_lvl = (mapped < lo) ? lo : mapped;
		target    = (floor_lvl > hi) ? hi : floor_lvl;
	end

	// avg * 7 + load, fits in 11 bits
	assign avg_sum = {state_q.load_avg, 3'b000} - {3'b000, state_q.load_avg}
		+ {3'b000, item.load_sample};

	always_comb begin
		nxt      = state_q;
		changed  = 1'b0;
		rejected = 1'b0;
		case (item.func)
			FN_CHECK: begin
				if (enabled && elapsed) begin
					nxt.last_check = item.now_ms;
					nxt.last_temp  = item.temp_sample;
					if ($signed(item.temp_sample) > $signed(state_q.peak))
						nxt.peak = item.temp_sample;
					if ($signed(item.temp_sample) > $signed(cfg.thermal_limit)) begin
						if (!state_q.throttle) begin
							nxt.throttle = 1'b1;
							nxt.thr_cnt  = state_q.thr_cnt + CNT_W'(1);
						end
						if (state_q.level > LVL_POWERSAVE) begin
							nxt.level     = state_q.level - 3'd1;
							nxt.trans_cnt = state_q.trans_cnt + CNT_W'(1);
							changed       = 1'b1;
						end
					end else begin
						nxt.throttle = 1'b0;
						if (cfg.mode == MODE_ONDEMAND && target != state_q.level) begin
							nxt.level     = target;
							nxt.trans_cnt = state_q.trans_cnt + CNT_W'(1);
							changed       = 1'b1;
						end
					end
				end
			end
			FN_LOAD: begin
				nxt.last_load = item.load_sample;
				nxt.load_avg  = avg_sum[10:3];
			end
			FN_MANUAL: begin
				if (item.wanted_level > LVL_TOP) begin
					rejected = 1'b1;
				end else if (cfg.mode == MODE_MANUAL) begin
					nxt.level     = item.wanted_level;
					nxt.trans_cnt = state_q.trans_cnt + CNT_W'(1);
					changed       = 1'b1;
				end
			end
			FN_BOOST: begin
				if (cfg.mode == MODE_ONDEMAND && !state_q.boost) begin
					nxt.boost = 1'b1;
					if (state_q.level < LVL_BALANCED) begin
						nxt.level = LVL_BALANCED;
						changed   = 1'b1;
					end
				end
			end
			FN_TURBO: begin
				if (turbo_ok) begin
					nxt.turbo = 1'b1;
					nxt.level = LVL_TOP;
					changed   = 1'b1;
				end
			end
			FN_INSTANT_TURBO: begin
				if (turbo_ok && state_q.level < LVL_TOP) begin
					nxt.turbo = 1'b1;
					nxt.level = LVL_TOP;
					changed   = 1'b1;
				end
			end
			FN_STATS_CLR: begin
				nxt.trans_cnt = '0;
				nxt.thr_cnt   = '0;
				nxt.peak      = state_q.last_temp;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.level      <= LVL_BALANCED;
			state_q.last_check <= '0;
			state_q.last_load  <= '0;
			state_q.load_avg   <= '0;
			state_q.peak       <= TEMP_MIN;
			state_q.last_temp  <= TEMP_MIN;
			state_q.throttle   <= 1'b0;
			state_q.thr_cnt    <= '0;
			state_q.trans_cnt  <= '0;
			state_q.boost      <= 1'b0;
			state_q.turbo      <= 1'b0;
		end else if (en) begin
			state_q <= nxt;
		end
	end

	always_comb begin
		res.level           = nxt.level;
		res.level_changed   = changed;
		res.high_voltage    = nxt.level >= LVL_PERF;
		res.throttled       = nxt.throttle;
		res.throttle_events = nxt.thr_cnt;
		res.transitions     = nxt.trans_cnt;
		res.load_average    = nxt.load_avg;
		res.peak_temp       = nxt.peak;
		res.boost_on        = nxt.boost;
		res.turbo_on        = nxt.turbo;
		res.rejected        = rejected;
	end

endmodule

`default_nettype wire

/* rtl/core/dvfs_governor_thermal_throttle.sv */
// Thermal-throttling five-level dvfs governor. One event enters per transaction and
// returns exactly one status transaction. The event is held in the input register while
// the update logic runs on it, and the result is then loaded into the result register,
// from which its status transaction completes. One event is taken per cycle while the
// status output is not stalled; the governor state is read and written by the single
// update stage, so back-to-back events see each other's effect. A stalled result holds
// the update stage and then the input. Configuration writes must only be issued while no
// event is in flight.
// depends on dvfs_gov_pkg, dvfs_gov_cfg, dvfs_gov_state
`default_nettype none

module dvfs_governor_thermal_throttle
	import dvfs_gov_pkg::*;
#(
	parameter int unsigned CHECK_INTERVAL = CHECK_INTERVAL_DEF,
	parameter int unsigned TURBO_ALLOWED  = TURBO_ALLOWED_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// event input
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// now_ms, temp_sample, load_sample, wanted_level
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// func
	input  wire logic [2:0]            s_tuser,
	// status output
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// level, level_changed, high_voltage, throttled, throttle_events, transitions,
	// load_average, peak_temp, boost_on, turbo_on, rejected, zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    valid_s2;
	result_t res;
	result_t res_s2;
	logic    adv_s2;
	logic    fire_s1;
	logic    take_in;

	assign adv_s2   = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;
	assign take_in  = s_tvalid && s_tready;

	dvfs_gov_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dvfs_gov_state #(
		.CHECK_INTERVAL (CHECK_INTERVAL),
		.TURBO_ALLOWED  (TURBO_ALLOWED)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (fire_s1)
				valid_s1 <= 1'b0;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.func         <= func_t'(s_tuser);
			item_s1.now_ms       <= s_tdata[31:0];
			item_s1.temp_sample  <= s_tdata[44:32];
			item_s1.load_sample  <= s_tdata[52:45];
			item_s1.wanted_level <= s_tdata[55:53];
		end
		if (fire_s1)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.rejected, res_s2.turbo_on, res_s2.boost_on,
		res_s2.peak_temp, res_s2.load_average, res_s2.transitions,
		res_s2.throttle_events, res_s2.throttled, res_s2.high_voltage,
		res_s2.level_changed, res_s2.level};

	// profile never leaves the five defined levels
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.level <= LVL_TOP)
		else $error("level out of range");

	// voltage flag follows the reported level
	a_high_voltage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.high_voltage == (res_s2.level >= LVL_PERF))
		else $error("high_voltage does not match level");

	// a rejected request never changes the profile
	a_reject_nochange: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.rejected |-> !res_s2.level_changed)
		else $error("rejected request changed level");

	// a held result is not overwritten by the update stage
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |=> $stable(res_s2))
		else $error("stalled result overwritten");

endmodule

`default_nettype wire
